### rtl/tdwa_pkg.sv
// Shared constants, types and sequencer states for the touch drag window average.
// No dependencies; imported by every module of the block.
package tdwa_pkg;

  localparam int WINDOW    = 8;
  localparam int DELTA_W   = 16;
  localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int SUM_W     = DELTA_W + $clog2(WINDOW);
  localparam int STEP_W    = $clog2(SUM_W + 1);
  localparam int ENTRIES_W = 4;
  localparam int ACTION_W  = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PRESS   = 2'd0,
    ACT_DRAG    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_OTHER   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_STARTX,
    S_WAITX,
    S_STARTY,
    S_WAITY,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic                      en;
    logic [SLOT_W-1:0]         addr;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } ring_wr_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/tdwa_ring.sv
// Ring store of the last WINDOW deltas, x and y side by side.
// One write port, one registered read port. Depends on tdwa_pkg.
module tdwa_ring
  import tdwa_pkg::*;
(
  input  logic                      clk,
  input  ring_wr_t                  wr,
  input  logic                      rd_en,
  input  logic [SLOT_W-1:0]         rd_addr,
  output logic signed [DELTA_W-1:0] rd_x,
  output logic signed [DELTA_W-1:0] rd_y
);

  logic [2*DELTA_W-1:0] mem [WINDOW];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.dy, wr.dx};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_y, rd_x} <= mem[rd_addr];
    end
  end

endmodule

### rtl/tdwa_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Divisor is a positive entry count. Depends on tdwa_pkg.
module tdwa_div
  import tdwa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [SUM_W-1:0]  mag;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvsr;
  logic [STEP_W-1:0] steps;
  logic              neg;
  logic              busy;
  logic              done;

  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign shifted = {rem, mag[SUM_W-1]};
  assign trial   = shifted - {1'b0, dvsr};
  assign fits    = (shifted >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: magnitude shifts out at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg  <= req.dividend[SUM_W-1];
      mag  <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
      rem  <= '0;
      dvsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
      mag <= {mag[SUM_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = neg ? SUM_W'(-$signed(mag)) : $signed(mag);

endmodule

### rtl/touch_drag_window_average.sv
// Touch drag window average: per-axis mean of the last WINDOW drag deltas.
// A request passes READ, UPDATE, then two 19-step serial divides (x, then y) before
// its result is registered in DONE; a press or empty window skips the divides.
// Requests are taken one at a time: ready is high only in IDLE, and the one serial divider serves both axes.
// Reset: synchronous, active high; clears count, oldest slot, sums and handshakes.
// Ring contents are not cleared; only written entries are ever used.
module touch_drag_window_average
  import tdwa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // pos_x[15:0], pos_y[31:16], prev_x[47:32], prev_y[63:48]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // avg_x[15:0], avg_y[31:16], entries[35:32], zero pad
);

  seq_state_t state, state_next;

  // captured request
  action_t                   action;
  logic signed [DELTA_W-1:0] pos_x, pos_y, prev_x, prev_y;

  // window state
  logic [SLOT_W-1:0]       oldest_slot;
  logic [CNT_W-1:0]        fill_count;
  logic signed [SUM_W-1:0] sum_x, sum_y;

  // per-request working registers
  logic signed [DELTA_W-1:0] dx, dy;
  logic signed [DELTA_W-1:0] avg_x, avg_y;

  // output register
  logic signed [DELTA_W-1:0] out_x, out_y;
  logic [ENTRIES_W-1:0]      out_entries;

  // ring and divider
  ring_wr_t                  ring_wr;
  logic                      ring_rd_en;
  logic signed [DELTA_W-1:0] old_x, old_y;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  // update arithmetic
  logic                      push;
  logic                      full;
  logic [CNT_W:0]            slot_raw;
  logic [SLOT_W-1:0]         push_slot;
  logic [SLOT_W-1:0]         oldest_next;
  logic [CNT_W-1:0]          fill_next;
  logic signed [SUM_W-1:0]   sum_x_next, sum_y_next;
  logic signed [DELTA_W:0]   diff_x, diff_y;
  logic                      out_free;

  tdwa_ring u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .rd_en   (ring_rd_en),
    .rd_addr (oldest_slot),
    .rd_x    (old_x),
    .rd_y    (old_y)
  );

  tdwa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // 17-bit differences, clipped to the 16-bit range
  assign diff_x = {pos_x[DELTA_W-1], pos_x} - {prev_x[DELTA_W-1], prev_x};
  assign diff_y = {pos_y[DELTA_W-1], pos_y} - {prev_y[DELTA_W-1], prev_y};

  // push position: first free slot while filling, otherwise the oldest one
  assign push     = (action == ACT_DRAG) || (action == ACT_RELEASE);
  assign full     = (fill_count == CNT_W'(WINDOW));
  assign slot_raw = {1'b0, CNT_W'(oldest_slot)} + {1'b0, fill_count};

  always_comb begin
    if (slot_raw >= (CNT_W+1)'(WINDOW)) begin
      push_slot = SLOT_W'(slot_raw - (CNT_W+1)'(WINDOW));
    end else begin
      push_slot = SLOT_W'(slot_raw);
    end
    if (full) begin
      push_slot = oldest_slot;
    end
  end

  always_comb begin
    oldest_next = oldest_slot;
    fill_next   = fill_count;
    sum_x_next  = sum_x;
    sum_y_next  = sum_y;
    case (action)
      ACT_PRESS: begin
        oldest_next = '0;
        fill_next   = '0;
        sum_x_next  = '0;
        sum_y_next  = '0;
      end
      ACT_DRAG, ACT_RELEASE: begin
        if (full) begin
          // evict the oldest delta, read out during READ
          oldest_next = (oldest_slot == SLOT_W'(WINDOW - 1)) ? '0 : oldest_slot + 1'b1;
          sum_x_next  = sum_x + SUM_W'(dx) - SUM_W'(old_x);
          sum_y_next  = sum_y + SUM_W'(dy) - SUM_W'(old_y);
        end else begin
          fill_next  = fill_count + 1'b1;
          sum_x_next = sum_x + SUM_W'(dx);
          sum_y_next = sum_y + SUM_W'(dy);
        end
      end
      default: begin
      end
    endcase
  end

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_axis_tvalid) state_next = S_READ;
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: state_next = (fill_next == '0) ? S_DONE : S_STARTX;
      S_STARTX: state_next = S_WAITX;
      S_WAITX:  if (div_rsp.done) state_next = S_STARTY;
      S_STARTY: state_next = S_WAITY;
      S_WAITY:  if (div_rsp.done) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs to ring and divider
  always_comb begin
    ring_rd_en       = (state == S_READ);
    ring_wr.en       = (state == S_UPDATE) && push;
    ring_wr.addr     = push_slot;
    ring_wr.dx       = dx;
    ring_wr.dy       = dy;
    div_req.start    = (state == S_STARTX) || (state == S_STARTY);
    div_req.dividend = (state == S_STARTY) ? sum_y : sum_x;
    div_req.divisor  = fill_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      oldest_slot   <= '0;
      fill_count    <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_UPDATE) begin
        oldest_slot <= oldest_next;
        fill_count  <= fill_next;
        sum_x       <= sum_x_next;
        sum_y       <= sum_y_next;
      end
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      action <= action_t'(s_axis_tuser);
      pos_x  <= s_axis_tdata[15:0];
      pos_y  <= s_axis_tdata[31:16];
      prev_x <= s_axis_tdata[47:32];
      prev_y <= s_axis_tdata[63:48];
    end
    if (state == S_READ) begin
      dx <= (diff_x[DELTA_W] != diff_x[DELTA_W-1]) ?
            {diff_x[DELTA_W], {(DELTA_W-1){!diff_x[DELTA_W]}}} : diff_x[DELTA_W-1:0];
      dy <= (diff_y[DELTA_W] != diff_y[DELTA_W-1]) ?
            {diff_y[DELTA_W], {(DELTA_W-1){!diff_y[DELTA_W]}}} : diff_y[DELTA_W-1:0];
    end
    if (state == S_UPDATE) begin
      avg_x <= '0;
      avg_y <= '0;
    end
    if (state == S_WAITX && div_rsp.done) avg_x <= div_rsp.quotient[DELTA_W-1:0];
    if (state == S_WAITY && div_rsp.done) avg_y <= div_rsp.quotient[DELTA_W-1:0];
    if (state == S_DONE && out_free) begin
      out_x       <= avg_x;
      out_y       <= avg_y;
      out_entries <= ENTRIES_W'(fill_count);
    end
  end

  assign m_axis_tdata = {4'b0000, out_entries, out_y, out_x};

`ifndef ASSERT_OFF
  // window never holds more than WINDOW deltas
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("fill count above window size");

  // a new request is never taken while the divider is running
  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_rsp.busy)
    else $error("request accepted while divider busy");

  // one request at a time: ready drops straight after acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready held after acceptance");

  // divider results arrive only while the sequencer waits for them
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_WAITX || state == S_WAITY))
    else $error("divider result outside a wait state");
`endif

endmodule

### tb/touch_drag_window_average_tb.sv
// Self-checking testbench for touch_drag_window_average: directed and random touch gestures, own window model.
// Depends on tdwa_pkg and the touch_drag_window_average RTL only.
`timescale 1ns / 1ps

module touch_drag_window_average_tb;
  import tdwa_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned TAIL_CYCLES  = 100;
  localparam int unsigned RANDOM_REQS  = 1200;

  typedef struct packed {
    action_t                   act;
    logic signed [DELTA_W-1:0] pos_x;
    logic signed [DELTA_W-1:0] pos_y;
    logic signed [DELTA_W-1:0] prev_x;
    logic signed [DELTA_W-1:0] prev_y;
    logic                      hold_for_drain; // sender waits until all results are back
  } touch_req_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] avg_x;
    logic signed [DELTA_W-1:0] avg_y;
    logic [ENTRIES_W-1:0]      entries;
  } drag_avg_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // pos_x, pos_y, prev_x, prev_y
  logic [1:0]  s_axis_tuser = '0;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // avg_x, avg_y, entries, zero pad

  touch_req_t  touch_q[$];
  drag_avg_t   avg_expect_q[$];
  int unsigned n_queued;
  int unsigned req_taken_cnt;  // bumped at the rising edge
  int unsigned req_sent_cnt;   // driver's own view
  int unsigned result_cnt;
  int unsigned rx_seen_cnt;
  int unsigned rx_stall;
  int unsigned tx_gap;
  bit          tx_quiet;
  bit          rx_quiet;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;

  // window model
  logic signed [DELTA_W-1:0] win_dx[WINDOW];
  logic signed [DELTA_W-1:0] win_dy[WINDOW];
  int unsigned               win_head;
  int unsigned               win_fill;
  int                        win_sum_x;
  int                        win_sum_y;

  touch_drag_window_average i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial forever #5 clk = ~clk;

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Apply one touch event to the window and return the averages it yields.
  function automatic drag_avg_t window_average(action_t act,
      logic signed [DELTA_W-1:0] px, logic signed [DELTA_W-1:0] py,
      logic signed [DELTA_W-1:0] qx, logic signed [DELTA_W-1:0] qy);
    int                dx;
    int                dy;
    logic [SLOT_W-1:0] slot;
    drag_avg_t         r;
    case (act)
      ACT_PRESS: begin
        win_fill  = 0;
        win_head  = 0;
        win_sum_x = 0;
        win_sum_y = 0;
      end
      ACT_DRAG, ACT_RELEASE: begin
        dx = clamp16(int'(px) - int'(qx));
        dy = clamp16(int'(py) - int'(qy));
        if (win_fill < WINDOW) begin
          slot = SLOT_W'((win_head + win_fill) % WINDOW);
          win_fill++;
        end else begin
          // full: oldest delta drops out of the sums
          slot = SLOT_W'(win_head);
          win_sum_x -= int'(win_dx[slot]);
          win_sum_y -= int'(win_dy[slot]);
          win_head = (slot + 1) % WINDOW;
        end
        win_dx[slot] = DELTA_W'(dx);
        win_dy[slot] = DELTA_W'(dy);
        win_sum_x += dx;
        win_sum_y += dy;
      end
      default: ;
    endcase
    r.avg_x   = '0;
    r.avg_y   = '0;
    r.entries = ENTRIES_W'(win_fill);
    if (win_fill > 0) begin
      // int division truncates toward zero
      r.avg_x = DELTA_W'(win_sum_x / int'(win_fill));
      r.avg_y = DELTA_W'(win_sum_y / int'(win_fill));
    end
    return r;
  endfunction

  task automatic queue_touch(action_t act, logic signed [DELTA_W-1:0] px,
      logic signed [DELTA_W-1:0] py, logic signed [DELTA_W-1:0] qx,
      logic signed [DELTA_W-1:0] qy);
    touch_req_t r;
    r.act            = act;
    r.pos_x          = px;
    r.pos_y          = py;
    r.prev_x         = qx;
    r.prev_y         = qy;
    r.hold_for_drain = (n_queued % 500 == 499);
    touch_q.push_back(r);
    n_queued++;
  endtask

  // Stimulus, then end-of-run check.
  initial begin
    logic signed [DELTA_W-1:0] cx;
    logic signed [DELTA_W-1:0] cy;
    logic signed [DELTA_W-1:0] ox;
    logic signed [DELTA_W-1:0] oy;
    int                        len;
    int                        i;

    // directed: empty window, saturation both ways, wrap of a full window
    queue_touch(ACT_OTHER, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_touch(ACT_PRESS, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_touch(ACT_DRAG, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    queue_touch(ACT_RELEASE, -16'sd3, 16'sd0, 16'sd0, -16'sd5);
    for (i = 0; i < 8; i++)
      queue_touch(ACT_DRAG, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    queue_touch(ACT_OTHER, 16'sh1234, -16'sd77, 16'sh7fff, 16'sh8000);
    for (i = 0; i < 8; i++)
      queue_touch(ACT_RELEASE, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    queue_touch(ACT_DRAG, 16'sh4321, -16'sd9, 16'sh4321, -16'sd9);
    queue_touch(ACT_PRESS, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    queue_touch(ACT_OTHER, 16'sd1, 16'sd1, 16'sd0, 16'sd0);
    queue_touch(ACT_DRAG, -16'sd1, 16'sd1, 16'sd0, 16'sd0);
    queue_touch(ACT_DRAG, 16'sd0, 16'sd0, 16'sd0, 16'sd0);

    // random: mostly press / drags / release gestures, some noise
    while (n_queued < RANDOM_REQS) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_touch(action_t'($urandom_range(0, 3)), DELTA_W'($urandom), DELTA_W'($urandom),
                    DELTA_W'($urandom), DELTA_W'($urandom));
      end else begin
        cx = DELTA_W'($urandom);
        cy = DELTA_W'($urandom);
        queue_touch(ACT_PRESS, cx, cy, DELTA_W'($urandom), DELTA_W'($urandom));
        len = $urandom_range(1, 20);
        for (i = 0; i <= len; i++) begin
          ox = cx;
          oy = cy;
          // small steps mostly, the odd jump to hit saturation
          if ($urandom_range(0, 3) == 0) begin
            cx = DELTA_W'($urandom);
            cy = DELTA_W'($urandom);
          end else begin
            cx = cx + DELTA_W'(int'($urandom_range(0, 512)) - 256);
            cy = cy + DELTA_W'(int'($urandom_range(0, 512)) - 256);
          end
          if ($urandom_range(0, 15) == 0)
            queue_touch(ACT_OTHER, cx, cy, ox, oy);
          else
            queue_touch((i == len) ? ACT_RELEASE : ACT_DRAG, cx, cy, ox, oy);
        end
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (req_taken_cnt == n_queued);
    wait (avg_expect_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Request driver: one nonblocking write of tvalid per falling edge.
  always @(negedge clk) begin
    logic       nv;
    touch_req_t r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      nv = s_axis_tvalid;
      if (s_axis_tvalid && req_taken_cnt != req_sent_cnt) begin
        req_sent_cnt = req_taken_cnt;
        nv = 1'b0;
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (touch_q.size() > 0 &&
                     !(touch_q[0].hold_for_drain && avg_expect_q.size() > 0)) begin
          r = touch_q.pop_front();
          s_axis_tdata <= {r.prev_y, r.prev_x, r.pos_y, r.pos_x};
          s_axis_tuser <= r.act;
          nv = 1'b1;
          if ($urandom_range(0, 63) == 0)
            tx_quiet = !tx_quiet;
          tx_gap = tx_quiet ? 0 : $urandom_range(0, 15);
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // Result receiver: random stall per result, two long hold-offs to back up the input.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (rx_seen_cnt != result_cnt) begin
        rx_seen_cnt = result_cnt;
        if ($urandom_range(0, 63) == 0)
          rx_quiet = !rx_quiet;
        rx_stall = rx_quiet ? 0 : $urandom_range(0, 15);
        if (rx_seen_cnt == 150 || rx_seen_cnt == 700)
          rx_stall = LONG_HOLD;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Accepted requests feed the window model; accepted results are checked.
  always @(posedge clk) begin
    drag_avg_t want;
    drag_avg_t got;
    if (rst) begin
      win_head  = 0;
      win_fill  = 0;
      win_sum_x = 0;
      win_sum_y = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        avg_expect_q.push_back(window_average(action_t'(s_axis_tuser),
            s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32],
            s_axis_tdata[63:48]));
        req_taken_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt++;
        got.avg_x   = m_axis_tdata[15:0];
        got.avg_y   = m_axis_tdata[31:16];
        got.entries = m_axis_tdata[35:32];
        if (avg_expect_q.size() == 0) begin
          $error("unexpected result: avg_x %0d avg_y %0d entries %0d",
                 got.avg_x, got.avg_y, got.entries);
          fail_cnt++;
        end else begin
          want = avg_expect_q.pop_front();
          if (got.avg_x !== want.avg_x) begin
            $error("avg_x mismatch: expected %0d, got %0d", want.avg_x, got.avg_x);
            fail_cnt++;
          end
          if (got.avg_y !== want.avg_y) begin
            $error("avg_y mismatch: expected %0d, got %0d", want.avg_y, got.avg_y);
            fail_cnt++;
          end
          if (got.entries !== want.entries) begin
            $error("entries mismatch: expected %0d, got %0d", want.entries, got.entries);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

### filelist.f
rtl/tdwa_pkg.sv
rtl/tdwa_ring.sv
rtl/tdwa_div.sv
rtl/touch_drag_window_average.sv
tb/touch_drag_window_average_tb.sv
